### rtl/core/rpsu_pkg.sv
// ----------------------------------------------------------------------------
// RPROP step size update package
// Shared widths, register codes, sign codes and types for the step size
// update block.
// ----------------------------------------------------------------------------
package rpsu_pkg;

  localparam int ELEMENTS_DEF = 1024;
  localparam int IDX_W        = 10;
  localparam int GRAD_W       = 32;
  localparam int STEP_W       = 32;
  localparam int FACTOR_W     = 16;
  localparam int DELTA_W      = 33;
  localparam int SIGN_W       = 2;
  localparam int FRAC_SHIFT   = 14;
  localparam int PROD_W       = STEP_W + FACTOR_W;
  localparam int ENTRY_W      = STEP_W + SIGN_W;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = FIFO_PW + 1;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [STEP_W-1:0]   STEP_ONE   = 32'd16777216;
  localparam logic [PROD_W:0]     ROUND_HALF = 49'd8192;

  localparam logic [FACTOR_W-1:0] SHRINK_RST   = 16'd8192;
  localparam logic [FACTOR_W-1:0] GROW_RST     = 16'd19661;
  localparam logic [STEP_W-1:0]   MIN_STEP_RST = 32'd1678;
  localparam logic [STEP_W-1:0]   MAX_STEP_RST = 32'd838860800;

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  localparam logic [1:0] REG_SHRINK   = 2'd0;
  localparam logic [1:0] REG_GROW     = 2'd1;
  localparam logic [1:0] REG_MIN_STEP = 2'd2;
  localparam logic [1:0] REG_MAX_STEP = 2'd3;

  typedef struct packed {
    logic [FACTOR_W-1:0] shrink_factor;
    logic [FACTOR_W-1:0] grow_factor;
    logic [STEP_W-1:0]   min_step;
    logic [STEP_W-1:0]   max_step;
  } cfg_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [SIGN_W-1:0] sign;
  } entry_t;

endpackage

### rtl/core/rprop_step_size_update_top.sv
// ----------------------------------------------------------------------------
// RPROP step size update, top level
// Keeps a step size and previous gradient sign per weight element and turns
// each incoming gradient into a weight delta.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction carries element_index and gradient on a valid/ready
// channel. Each one produces exactly one output transaction with element_out
// and weight_delta, in order. Per-element state lives in a RAM with a
// registered read; the accept cycle issues the read and the next cycle
// scales, clamps and writes the entry back, forwarding the entry written
// in the previous cycle. Results pass the update stage register and the
// output buffer; one result per cycle is sustained while out_ready is high.
// Results queue in a four-entry output buffer; when the receiver stalls,
// in_ready drops once the buffer and the update stage together hold four
// results. After reset the block writes the reset value to every RAM entry,
// one per cycle, with in_ready low throughout. Registers on
// the APB port may be written during that time. Indexes at or above
// ELEMENTS leave the state alone and return a zero delta.
// ----------------------------------------------------------------------------
module rprop_step_size_update_top
  import rpsu_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [IDX_W-1:0]          element_index,
  input  logic signed [GRAD_W-1:0]  gradient,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          element_out,
  output logic signed [DELTA_W-1:0] weight_delta
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  cfg_t                      cfg;
  logic                      clearing;
  logic [AW-1:0]             clr_addr;
  logic                      s1_valid;
  logic                      s1_in_range;
  logic [IDX_W-1:0]          s1_index;
  logic [SIGN_W-1:0]         s1_sign;
  logic [AW-1:0]             s1_addr;
  logic                      fwd_valid;
  logic [AW-1:0]             fwd_addr;
  entry_t                    fwd_entry;
  logic [IDX_W-1:0]          fifo_index [FIFO_DEPTH];
  logic signed [DELTA_W-1:0] fifo_delta [FIFO_DEPTH];
  logic [FIFO_PW-1:0]        wr_ptr;
  logic [FIFO_PW-1:0]        rd_ptr;
  logic [FIFO_CW-1:0]        fifo_count;

  logic                      in_accept;
  logic                      cfg_write;
  logic [SIGN_W-1:0]         in_sign;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  entry_t                    ram_wdata;
  logic [ENTRY_W-1:0]        ram_rdata;
  entry_t                    s1_entry;
  logic [STEP_W-1:0]         new_step;
  logic signed [DELTA_W-1:0] upd_delta;
  logic signed [DELTA_W-1:0] s1_delta;
  logic                      push;
  logic                      pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shrink_factor <= SHRINK_RST;
      cfg.grow_factor   <= GROW_RST;
      cfg.min_step      <= MIN_STEP_RST;
      cfg.max_step      <= MAX_STEP_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SHRINK:   cfg.shrink_factor <= pwdata[FACTOR_W-1:0];
        REG_GROW:     cfg.grow_factor   <= pwdata[FACTOR_W-1:0];
        REG_MIN_STEP: cfg.min_step      <= pwdata[STEP_W-1:0];
        REG_MAX_STEP: cfg.max_step      <= pwdata[STEP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SHRINK:   prdata = PDATA_W'(cfg.shrink_factor);
      REG_GROW:     prdata = PDATA_W'(cfg.grow_factor);
      REG_MIN_STEP: prdata = PDATA_W'(cfg.min_step);
      REG_MAX_STEP: prdata = PDATA_W'(cfg.max_step);
      default:      prdata = '0;
    endcase
  end

  assign in_ready  = !clearing &&
                     ((fifo_count + FIFO_CW'(s1_valid)) < FIFO_CW'(FIFO_DEPTH));
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (gradient == '0) begin
      in_sign = SIGN_ZERO;
    end else if (gradient[GRAD_W-1]) begin
      in_sign = SIGN_NEG;
    end else begin
      in_sign = SIGN_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
    if (in_accept) begin
      s1_in_range <= (17'(element_index) < 17'(ELEMENTS));
      s1_index    <= element_index;
      s1_sign     <= in_sign;
      s1_addr     <= AW'(element_index);
    end
  end

  rpsu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ELEMENTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (AW'(element_index)),
    .rdata (ram_rdata)
  );

  assign s1_entry = (fwd_valid && fwd_addr == s1_addr) ? fwd_entry : entry_t'(ram_rdata);

  rpsu_update u_update (
    .cfg      (cfg),
    .entry    (s1_entry),
    .cur_sign (s1_sign),
    .new_step (new_step),
    .delta    (upd_delta)
  );

  always_comb begin
    if (clearing) begin
      ram_we         = 1'b1;
      ram_waddr      = clr_addr;
      ram_wdata.step = STEP_ONE;
      ram_wdata.sign = SIGN_ZERO;
    end else begin
      ram_we         = s1_valid && s1_in_range;
      ram_waddr      = s1_addr;
      ram_wdata.step = new_step;
      ram_wdata.sign = s1_sign;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= ram_we;
    end
    fwd_addr  <= ram_waddr;
    fwd_entry <= ram_wdata;
  end

  assign s1_delta = s1_in_range ? upd_delta : '0;
  assign push     = s1_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
    if (push) begin
      fifo_index[wr_ptr] <= s1_index;
      fifo_delta[wr_ptr] <= s1_delta;
    end
  end

  assign out_valid    = (fifo_count != '0);
  assign element_out  = fifo_index[rd_ptr];
  assign weight_delta = fifo_delta[rd_ptr];

  a_accept_reaches_update: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted transaction did not reach the update stage");

  a_no_buffer_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("result pushed into a full output buffer");

  a_clear_covers_all: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == AW'(ELEMENTS - 1))
    else $error("clearing pass ended before the last entry");

  a_no_update_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !in_accept)
    else $error("transaction in flight during the clearing pass");

endmodule

### rtl/core/rpsu_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rpsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rpsu_update.sv
// ----------------------------------------------------------------------------
// RPROP step update datapath
// Scales the stored step by the grow or shrink factor when the stored and
// current signs are both nonzero, clamps it and forms the signed weight delta.
// ----------------------------------------------------------------------------
module rpsu_update
  import rpsu_pkg::*;
(
  input  cfg_t                      cfg,
  input  entry_t                    entry,
  input  logic [SIGN_W-1:0]         cur_sign,
  output logic [STEP_W-1:0]         new_step,
  output logic signed [DELTA_W-1:0] delta
);

  logic [FACTOR_W-1:0]        factor;
  logic [PROD_W-1:0]          product;
  logic [PROD_W:0]            rounded_sum;
  logic [PROD_W-FRAC_SHIFT:0] rounded;
  logic [STEP_W-1:0]          scaled;
  logic [STEP_W-1:0]          chosen;
  logic [STEP_W-1:0]          capped_hi;

  always_comb begin
    factor      = (entry.sign == cur_sign) ? cfg.grow_factor : cfg.shrink_factor;
    product     = PROD_W'(entry.step) * PROD_W'(factor);
    rounded_sum = (PROD_W + 1)'(product) + ROUND_HALF;
    rounded     = rounded_sum[PROD_W:FRAC_SHIFT];
    scaled      = (|rounded[PROD_W-FRAC_SHIFT:STEP_W]) ? '1 : rounded[STEP_W-1:0];
    if (entry.sign != SIGN_ZERO && cur_sign != SIGN_ZERO) begin
      chosen = scaled;
    end else begin
      chosen = entry.step;
    end
    capped_hi = (chosen > cfg.max_step) ? cfg.max_step : chosen;
    new_step  = (capped_hi < cfg.min_step) ? cfg.min_step : capped_hi;
    case (cur_sign)
      SIGN_POS: delta = $signed(DELTA_W'(0) - {1'b0, new_step});
      SIGN_NEG: delta = $signed({1'b0, new_step});
      default:  delta = '0;
    endcase
  end

endmodule

### sim/tb_rprop_step_size_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPROP step size update testbench
// Streams gradient transactions into the block through valid/ready handshakes,
// keeps its own per-element step size and sign state, and checks every
// weight delta in order. It starts with a directed table and then runs random
// phases under several APB register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_rprop_step_size_update_top;
  import rpsu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK_ITEMS = 96;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 16;
  localparam logic signed [DELTA_W-1:0] DELTA_ONE = 33'sd16777216;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [DELTA_W-1:0] delta;
  } delta_item_t;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [GRAD_W-1:0]  grad;
    bit                        typed;
    logic signed [DELTA_W-1:0] delta;
  } directed_row_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [IDX_W-1:0]          element_index = '0;
  logic signed [GRAD_W-1:0]  gradient = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [IDX_W-1:0]          element_out;
  logic signed [DELTA_W-1:0] weight_delta;

  logic [STEP_W-1:0]   step_mem [ELEMENTS_DEF];
  logic [SIGN_W-1:0]   sign_mem [ELEMENTS_DEF];
  logic [FACTOR_W-1:0] shrink_cfg;
  logic [FACTOR_W-1:0] grow_cfg;
  logic [STEP_W-1:0]   min_cfg;
  logic [STEP_W-1:0]   max_cfg;

  delta_item_t   pending_deltas [$];
  directed_row_t dir_rows [24];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_reqs = 0;
  int            fail_count = 0;
  int            sent_count = 0;
  int            seen_count = 0;
  int            settings_count = 1;
  int            cycle_count = 0;

  rprop_step_size_update_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_index(element_index),
    .gradient     (gradient),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .element_out  (element_out),
    .weight_delta (weight_delta)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [DELTA_W-1:0] advance_step(
    input logic [IDX_W-1:0] idx,
    input logic signed [GRAD_W-1:0] g
  );
    logic [SIGN_W-1:0] cur;
    logic [SIGN_W-1:0] prev;
    logic [STEP_W-1:0] step;
    logic [PROD_W:0]   prod;
    cur = (g == '0) ? SIGN_ZERO : (g[GRAD_W-1] ? SIGN_NEG : SIGN_POS);
    if (idx >= ELEMENTS_DEF) return '0;
    prev = sign_mem[idx];
    step = step_mem[idx];
    if (prev != SIGN_ZERO && cur != SIGN_ZERO) begin
      prod = step * ((prev == cur) ? grow_cfg : shrink_cfg);
      prod = (prod + ROUND_HALF) >> FRAC_SHIFT;
      step = (prod > {{(PROD_W-STEP_W+1){1'b0}}, {STEP_W{1'b1}}}) ? '1 : prod[STEP_W-1:0];
    end
    if (step > max_cfg) step = max_cfg;
    if (step < min_cfg) step = min_cfg;
    step_mem[idx] = step;
    sign_mem[idx] = cur;
    case (cur)
      SIGN_POS: return -$signed({1'b0, step});
      SIGN_NEG: return $signed({1'b0, step});
      default:  return '0;
    endcase
  endfunction

  task automatic push_gradient(
    input logic [IDX_W-1:0] idx,
    input logic signed [GRAD_W-1:0] g,
    input bit typed,
    input logic signed [DELTA_W-1:0] typed_delta
  );
    delta_item_t want;
    logic signed [DELTA_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_index <= idx;
    gradient      <= g;
    do @(posedge clk); while (!in_ready);
    predicted  = advance_step(idx, g);
    want.idx   = idx;
    want.delta = typed ? typed_delta : predicted;
    pending_deltas.push_back(want);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_deltas.size() != 0);
  endtask

  task automatic apb_write(input logic [1:0] code, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {code, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (code)
      REG_SHRINK:   shrink_cfg = value[FACTOR_W-1:0];
      REG_GROW:     grow_cfg   = value[FACTOR_W-1:0];
      REG_MIN_STEP: min_cfg    = value[STEP_W-1:0];
      REG_MAX_STEP: max_cfg    = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [1:0] code, output logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {code, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
  endtask

  task automatic program_registers(
    input logic [FACTOR_W-1:0] shrink,
    input logic [FACTOR_W-1:0] grow,
    input logic [STEP_W-1:0]   lo,
    input logic [STEP_W-1:0]   hi
  );
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] want;
    logic [15:0]        junk;
    logic [1:0]         code;
    junk = 16'($urandom());
    apb_write(REG_SHRINK, {junk, shrink});
    junk = 16'($urandom());
    apb_write(REG_GROW, {junk, grow});
    apb_write(REG_MIN_STEP, lo);
    apb_write(REG_MAX_STEP, hi);
    for (int r = 0; r < 4; r++) begin
      code = 2'(r);
      apb_read(code, rd);
      case (code)
        REG_SHRINK:   want = PDATA_W'(shrink_cfg);
        REG_GROW:     want = PDATA_W'(grow_cfg);
        REG_MIN_STEP: want = min_cfg;
        default:      want = max_cfg;
      endcase
      if (code == REG_SHRINK || code == REG_GROW) rd[PDATA_W-1:FACTOR_W] = '0;
      if (rd !== want) begin
        $error("prdata of register %0d: expected %h, got %h", code, want, rd);
        fail_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_count++;
  endtask

  task automatic random_chunk(input int count);
    logic [IDX_W-1:0]         pool [8];
    bit                       pool_neg [8];
    bit                       pool_alt [8];
    int                       pool_n;
    int                       slot;
    int                       pick;
    logic [IDX_W-1:0]         idx;
    logic signed [GRAD_W-1:0] g;
    pool_n = $urandom_range(8, 1);
    for (int i = 0; i < 8; i++) begin
      pool[i]     = IDX_W'($urandom_range(ELEMENTS_DEF - 1));
      pool_neg[i] = 1'($urandom_range(1));
      pool_alt[i] = 1'($urandom_range(1));
    end
    for (int n = 0; n < count; n++) begin
      slot = $urandom_range(pool_n - 1);
      if ($urandom_range(99) < 10) pool_alt[slot] = !pool_alt[slot];
      if (pool_alt[slot]) pool_neg[slot] = !pool_neg[slot];
      if ($urandom_range(99) < 20) idx = IDX_W'($urandom_range(ELEMENTS_DEF - 1));
      else idx = pool[slot];
      pick = $urandom_range(99);
      if (pick < 8) begin
        g = '0;
      end else if (pick < 16) begin
        case ($urandom_range(3))
          0:       g = 32'sh7FFF_FFFF;
          1:       g = 32'sh8000_0000;
          2:       g = 32'sd1;
          default: g = -32'sd1;
        endcase
      end else begin
        g = $urandom();
        g[GRAD_W-1] = pool_neg[slot];
        if (g == '0) g = 32'sd1;
      end
      push_gradient(idx, g, 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_deltas
    delta_item_t want;
    if (!rst && out_valid && out_ready) begin
      seen_count++;
      if (pending_deltas.size() == 0) begin
        $error("unexpected result transaction: element_out %0d, weight_delta %0d",
               element_out, weight_delta);
        fail_count++;
      end else begin
        want = pending_deltas.pop_front();
        if (element_out !== want.idx) begin
          $error("element_out: expected %0d, got %0d", want.idx, element_out);
          fail_count++;
        end
        if (weight_delta !== want.delta) begin
          $error("weight_delta: expected %0d, got %0d", want.delta, weight_delta);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < ELEMENTS_DEF; i++) begin
      step_mem[i] = STEP_ONE;
      sign_mem[i] = SIGN_ZERO;
    end
    shrink_cfg = SHRINK_RST;
    grow_cfg   = GROW_RST;
    min_cfg    = MIN_STEP_RST;
    max_cfg    = MAX_STEP_RST;

    dir_rows = '{
      '{10'd0,     32'sd1,          1'b1, -DELTA_ONE},
      '{10'd0,     32'sh7FFF_FFFF,  1'b0, '0},
      '{10'd0,     -32'sd1,         1'b0, '0},
      '{10'd0,     32'sd0,          1'b1, '0},
      '{10'd0,     32'sd5,          1'b0, '0},
      '{10'd1023,  32'sh7FFF_FFFF,  1'b1, -DELTA_ONE},
      '{10'd1023,  32'sh8000_0000,  1'b0, '0},
      '{10'd1023,  32'sh8000_0000,  1'b0, '0},
      '{10'd512,   -32'sd1,         1'b1, DELTA_ONE},
      '{10'd1,     32'sd0,          1'b1, '0},
      '{10'd1,     -32'sd3,         1'b1, DELTA_ONE},
      '{10'd2,     32'sd1,          1'b1, -DELTA_ONE},
      '{10'd2,     32'sd1,          1'b0, '0},
      '{10'd2,     32'sd1,          1'b0, '0},
      '{10'd2,     32'sd1,          1'b0, '0},
      '{10'd2,     32'sd1,          1'b0, '0},
      '{10'd2,     32'sd1,          1'b0, '0},
      '{10'd2,     32'sd1,          1'b0, '0},
      '{10'd3,     32'sd9,          1'b1, -DELTA_ONE},
      '{10'd3,     -32'sd9,         1'b0, '0},
      '{10'd3,     32'sd9,          1'b0, '0},
      '{10'd3,     -32'sd9,         1'b0, '0},
      '{10'h2AA,   32'sh5555_5555,  1'b1, -DELTA_ONE},
      '{10'h155,   32'shAAAA_AAAA,  1'b1, DELTA_ONE}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 65;
    foreach (dir_rows[i])
      push_gradient(dir_rows[i].idx, dir_rows[i].grad, dir_rows[i].typed, dir_rows[i].delta);
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: program_registers(16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
        2: program_registers(16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0);
        3: program_registers(16'($urandom()), 16'($urandom()), 32'h0, 32'h0);
        4: program_registers(16'($urandom()), 16'($urandom()), $urandom(), $urandom());
        5: program_registers(16'($urandom_range(16383)), 16'($urandom_range(65535, 16384)),
                             $urandom_range(32'h0010_0000),
                             $urandom_range(32'hFFFF_FFFF, 32'h0100_0000));
        default: ;
      endcase
      for (int mode = 0; mode < 3; mode++) begin
        case (mode)
          0: begin send_idle_pct = 16; recv_idle_pct = 65; end
          1: begin send_idle_pct = 65; recv_idle_pct = 16; end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        // The long receiver hold-off lets the sender back up into the block.
        if (mode == 2 && (phase == 0 || phase == 4)) hold_reqs <= hold_reqs + 1;
        random_chunk(CHUNK_ITEMS);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d gradient transactions and %0d weight delta transactions",
             sent_count, seen_count);
    $display("across %0d register settings and three handshake idle patterns.",
             settings_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### rprop_step_size_update_top.f
rtl/core/rpsu_pkg.sv
rtl/core/rpsu_ram.sv
rtl/core/rpsu_update.sv
rtl/core/rprop_step_size_update_top.sv
sim/tb_rprop_step_size_update_top.sv
